// ===== hdl/lru_replacer_top_assert.svh =====
// Assertion macros shared by the LRU replacement list modules.
`ifndef LRU_REPLACER_TOP_ASSERT_SVH
`define LRU_REPLACER_TOP_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define LRU_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("LRU replacer assertion failed");

// Same-cycle implication.
`define LRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("LRU replacer assertion failed");

// Next-cycle implication.
`define LRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("LRU replacer assertion failed");

`endif

// ===== hdl/lru_rep_pkg.sv =====
// Shared types and constants of the LRU replacement list.
package lru_rep_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int CMD_W       = 2;
  localparam int KEY_FIELD_W = 16;
  localparam int IN_TDATA_W  = 24;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

  typedef struct packed {
    logic capture;
    logic apply;
  } lru_rep_cmd_t;

endpackage

// ===== hdl/lru_replacer_top.sv =====
// Top level of the LRU replacement list: stream ports, controller and datapath.
// The key of each command is compared against all held entries as it is accepted, and
// the list update and result are written in the update state after it; a stalled result
// holds the update state until the output register frees up. A new command is accepted
// only once the previous one has been written.
// Synchronous active-low reset empties the list and clears the handshake state.
module lru_replacer_top #(
  parameter  int DEPTH     = lru_rep_pkg::DEPTH_DEF,
  parameter  int KEY_BITS  = lru_rep_pkg::KEY_BITS_DEF,
  localparam int CntW      = $clog2(DEPTH + 1),
  localparam int OutBits   = 2 * 1 + lru_rep_pkg::KEY_FIELD_W + CntW,
  localparam int OutTdataW = ((OutBits + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cmd [1:0], key [17:2], zero fill above.
  input  logic [lru_rep_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // victim_key [15:0], ok [16], full_refused [17], count above, zero fill above.
  output logic [OutTdataW-1:0]               out_tdata
);

  lru_rep_pkg::lru_rep_cmd_t               cmd;
  logic [lru_rep_pkg::KEY_FIELD_W-1:0]     victim_key;
  logic                                    ok;
  logic                                    full_refused;
  logic [CntW-1:0]                         count;

  lru_rep_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lru_rep_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_cmd       (in_tdata[lru_rep_pkg::CMD_W-1:0]),
    .in_key       (in_tdata[lru_rep_pkg::CMD_W +: lru_rep_pkg::KEY_FIELD_W]),
    .victim_key   (victim_key),
    .ok           (ok),
    .full_refused (full_refused),
    .count        (count)
  );

  always_comb begin
    out_tdata              = '0;
    out_tdata[OutBits-1:0] = {count, full_refused, ok, victim_key};
  end

endmodule

// ===== hdl/lru_rep_ctrl.sv =====
// Controller state machine of the LRU replacement list.
`include "lru_replacer_top_assert.svh"

module lru_rep_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output lru_rep_pkg::lru_rep_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready   = (state_r == ST_IDLE);
  assign out_tvalid  = out_valid_r;
  assign slot_free   = !out_valid_r || out_tready;
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.apply   = (state_r == ST_APPLY) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LRU_ASSERT_IMPL(a_rise_after_apply, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_APPLY))
  `LRU_ASSERT_IMPL(a_apply_from_state, clk, rst_n, cmd.apply, !in_tready)

endmodule

// ===== hdl/lru_rep_dp.sv =====
// Datapath of the LRU replacement list: ordered key cells, compare-all match and result register.
`include "lru_replacer_top_assert.svh"

module lru_rep_dp #(
  parameter  int DEPTH    = lru_rep_pkg::DEPTH_DEF,
  parameter  int KEY_BITS = lru_rep_pkg::KEY_BITS_DEF,
  localparam int CntW     = $clog2(DEPTH + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lru_rep_pkg::lru_rep_cmd_t              cmd,
  input  logic [lru_rep_pkg::CMD_W-1:0]          in_cmd,
  input  logic [lru_rep_pkg::KEY_FIELD_W-1:0]    in_key,
  output logic [lru_rep_pkg::KEY_FIELD_W-1:0]    victim_key,
  output logic                                   ok,
  output logic                                   full_refused,
  output logic [CntW-1:0]                        count
);

  localparam int IdxW = $clog2(DEPTH);

  logic [KEY_BITS-1:0]           key_ext;
  logic [KEY_BITS-1:0]           list_r   [DEPTH];
  logic [KEY_BITS-1:0]           list_nxt [DEPTH];
  logic [CntW-1:0]               count_r, count_nxt;
  logic [lru_rep_pkg::CMD_W-1:0] op_r;
  logic [KEY_BITS-1:0]           key_r;
  logic [DEPTH-1:0]              match_r;
  logic [DEPTH-1:0]              at_or_after;
  logic [DEPTH-1:0]              low_mask;
  logic                          hit;
  logic                          full;
  logic [CntW-1:0]               cnt_m1;
  logic [IdxW-1:0]               tail_idx;
  logic [KEY_BITS-1:0]           victim_nxt, victim_r;
  logic                          ok_nxt, ok_r;
  logic                          refused_nxt, refused_r;

  for (genvar g = 0; g < KEY_BITS; g++) begin : g_key_in
    if (g < lru_rep_pkg::KEY_FIELD_W) begin : g_bit
      assign key_ext[g] = in_key[g];
    end else begin : g_zero
      assign key_ext[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < lru_rep_pkg::KEY_FIELD_W; g++) begin : g_key_out
    if (g < KEY_BITS) begin : g_bit
      assign victim_key[g] = victim_r[g];
    end else begin : g_zero
      assign victim_key[g] = 1'b0;
    end
  end

  assign ok           = ok_r;
  assign full_refused = refused_r;
  assign count        = count_r;

  assign hit      = |match_r;
  assign full     = (count_r == CntW'(DEPTH));
  assign cnt_m1   = count_r - 1'b1;
  assign tail_idx = cnt_m1[IdxW-1:0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      low_mask = '0;
      for (int j = 0; j <= i; j++) begin
        low_mask[j] = 1'b1;
      end
      at_or_after[i] = |(match_r & low_mask);
    end
  end

  always_comb begin
    list_nxt    = list_r;
    count_nxt   = count_r;
    victim_nxt  = '0;
    ok_nxt      = 1'b0;
    refused_nxt = 1'b0;
    unique case (op_r)
      lru_rep_pkg::CMD_INSERT: begin
        if (hit || !full) begin
          list_nxt[0] = key_r;
          for (int i = 1; i < DEPTH; i++) begin
            if (!at_or_after[i-1]) list_nxt[i] = list_r[i-1];
          end
          if (!hit) count_nxt = count_r + 1'b1;
          ok_nxt = 1'b1;
        end else begin
          refused_nxt = 1'b1;
        end
      end
      lru_rep_pkg::CMD_VICTIM: begin
        if (count_r != '0) begin
          victim_nxt = list_r[tail_idx];
          count_nxt  = cnt_m1;
          ok_nxt     = 1'b1;
        end
      end
      lru_rep_pkg::CMD_ERASE: begin
        if (hit) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (at_or_after[i]) list_nxt[i] = list_r[i+1];
          end
          count_nxt = cnt_m1;
          ok_nxt    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_cmd;
      key_r <= key_ext;
      for (int i = 0; i < DEPTH; i++) begin
        match_r[i] <= (CntW'(i) < count_r) && (list_r[i] == key_ext);
      end
    end
    if (cmd.apply) begin
      list_r    <= list_nxt;
      victim_r  <= victim_nxt;
      ok_r      <= ok_nxt;
      refused_r <= refused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  `LRU_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CntW'(DEPTH))
  `LRU_ASSERT_IMPL(a_keys_distinct, clk, rst_n, cmd.apply, $onehot0(match_r))
  `LRU_ASSERT_NEXT(a_count_hold, clk, rst_n, !cmd.apply, $stable(count_r))

endmodule
